[hw/rtl/ipl_pkg.sv]
// Shared types and constants for the piecewise-linear lookup table.
// No dependencies.
package ipl_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DW         = 32;
  localparam int QW         = 2 * DW + 1;          // rounded numerator / quotient width
  localparam int DIV_CNT_W  = $clog2(QW + 1);

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef struct packed {
    action_t                 act;
    logic [IDX_W-1:0]        idx;
    logic signed [DW-1:0]    px;
    logic signed [DW-1:0]    py;
    logic signed [DW-1:0]    qx;
  } item_t;

endpackage

[hw/rtl/int_piecewise_linear_lut.sv]
// Integer piecewise-linear interpolation lookup table, top level.
// A lookup goes from S_IDLE straight to S_DONE for an empty table, else through S_FIRST (low-end
// clamp), S_LAST (high-end clamp), the binary search, S_CALC (zero-width interval), S_MUL,
// S_DINIT and a 65-step serial divider to S_DONE. A write is done in the back end's idle state.
// Throughput: one transaction at a time in the back end; the 2-entry front queue and the
// output register let input and output stall independently.
// Reset (rst, synchronous): clears points_in_use, the front queue and the output valid flag; table content undefined.
module int_piecewise_linear_lut (
  input  logic                          clk,
  input  logic                          rst,
  // input transactions
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [ipl_pkg::IDX_W-1:0]     point_index,
  input  logic signed [ipl_pkg::DW-1:0] point_x,
  input  logic signed [ipl_pkg::DW-1:0] point_y,
  input  logic signed [ipl_pkg::DW-1:0] query_x,
  // result transactions
  output logic                          empty,
  input  logic                          pop,
  output logic signed [ipl_pkg::DW-1:0] interp_y,
  // points_in_use register
  input  logic                          cfg_we,
  input  logic [ipl_pkg::CNT_W-1:0]     cfg_wdata
);

  logic [ipl_pkg::CNT_W-1:0] points_in_use;
  logic [ipl_pkg::CNT_W-1:0] n_pts;
  logic                      head_valid;
  logic                      head_pop;
  ipl_pkg::item_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
    end else if (cfg_we) begin
      points_in_use <= cfg_wdata;
    end
  end

  // counts above the table size act as a full table
  assign n_pts = (points_in_use > ipl_pkg::CNT_W'(ipl_pkg::MAX_POINTS))
               ? ipl_pkg::CNT_W'(ipl_pkg::MAX_POINTS) : points_in_use;

  ipl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .query_x     (query_x),
    .head_valid  (head_valid),
    .head        (head),
    .head_pop    (head_pop)
  );

  ipl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .n_pts      (n_pts),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .interp_y   (interp_y)
  );

endmodule

[hw/rtl/ipl_front.sv]
// Front end: accepts transactions, classifies them and holds them in a short queue.
// Depends on ipl_pkg.
module ipl_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [ipl_pkg::IDX_W-1:0]     point_index,
  input  logic signed [ipl_pkg::DW-1:0] point_x,
  input  logic signed [ipl_pkg::DW-1:0] point_y,
  input  logic signed [ipl_pkg::DW-1:0] query_x,
  output logic                          head_valid,
  output ipl_pkg::item_t                head,
  input  logic                          head_pop
);

  ipl_pkg::item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  ipl_pkg::item_t in_item;

  always_comb begin
    in_item.act = action ? ipl_pkg::ACT_LOOKUP : ipl_pkg::ACT_WRITE;
    in_item.idx = point_index;
    in_item.px  = point_x;
    in_item.py  = point_y;
    in_item.qx  = query_x;
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("front queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !do_pop)
    else $error("pop from empty front queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 2'd1)
    else $error("front queue count lost a push");

endmodule

[hw/rtl/ipl_back.sv]
// Back end: breakpoint memory, binary search, multiply, serial divide, result register.
// Depends on ipl_pkg.
module ipl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ipl_pkg::CNT_W-1:0]     n_pts,
  input  logic                          head_valid,
  input  ipl_pkg::item_t                head,
  output logic                          head_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [ipl_pkg::DW-1:0] interp_y
);

  localparam int DW = ipl_pkg::DW;
  localparam int IW = ipl_pkg::IDX_W;
  localparam int QW = ipl_pkg::QW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FIRST  = 9'b000000010,
    S_LAST   = 9'b000000100,
    S_SEARCH = 9'b000001000,
    S_CALC   = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_DINIT  = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  logic [2*DW-1:0] mem [ipl_pkg::MAX_POINTS];
  logic [IW-1:0]   raddr_c;
  logic signed [DW-1:0] rx;
  logic signed [DW-1:0] ry;

  logic signed [DW-1:0] qx;
  logic signed [DW-1:0] xlo, ylo, xhi, yhi;
  logic [IW-1:0]   lo, hi, mid;
  logic [DW-1:0]   mag_dy, mag_dq, den;
  logic            neg;
  logic [2*DW-1:0] num;
  logic [QW-1:0]   dvd;
  logic [DW-1:0]   rem;
  logic [ipl_pkg::DIV_CNT_W-1:0] cnt;
  logic signed [DW-1:0] result;
  logic            out_valid;
  logic signed [DW-1:0] result_out;
  // Division results land in S_DONE through a flag so the final add uses the quotient.
  logic            from_div;

  // search step helpers
  logic            s_lt;
  logic [IW-1:0]   lo_n, hi_n;
  logic [IW:0]     mid_sum;
  logic            more;
  // calc helpers
  logic signed [DW:0] dx, dy, dq;
  // divider step
  logic [DW:0]     rem_sh;
  logic            q_bit;
  // final step
  logic [DW:0]     quo_sat;
  logic signed [DW+2:0] res_wide;
  logic signed [DW-1:0] res_sat;

  always_comb begin
    s_lt    = qx < rx;
    lo_n    = s_lt ? lo : mid;
    hi_n    = s_lt ? mid : hi;
    if (state == S_LAST) begin
      lo_n = lo;
      hi_n = hi;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    more    = ({1'b0, hi_n} - {1'b0, lo_n}) > {{IW{1'b0}}, 1'b1};
  end

  always_comb begin
    raddr_c = '0;
    case (state)
      S_FIRST:  raddr_c = IW'(n_pts - 1'b1);
      S_LAST,
      S_SEARCH: raddr_c = mid_sum[IW:1];
      default:  raddr_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && head_valid && head.act == ipl_pkg::ACT_WRITE) begin
      mem[head.idx] <= {head.px, head.py};
    end
    {rx, ry} <= mem[raddr_c];
  end

  always_comb begin
    dx = {xhi[DW-1], xhi} - {xlo[DW-1], xlo};
    dy = {yhi[DW-1], yhi} - {ylo[DW-1], ylo};
    dq = {qx[DW-1], qx} - {xlo[DW-1], xlo};
  end

  always_comb begin
    rem_sh = {rem, dvd[QW-1]};
    q_bit  = rem_sh >= {1'b0, den};
  end

  always_comb begin
    quo_sat  = (dvd > QW'(64'h1_0000_0000)) ? {1'b1, {DW{1'b0}}} : dvd[DW:0];
    res_wide = neg ? (DW+3)'(ylo) - $signed({2'b00, quo_sat})
                   : (DW+3)'(ylo) + $signed({2'b00, quo_sat});
    // top bits all equal: the sum fits in 32 bits
    if (res_wide[DW+2:DW-1] == '0 || res_wide[DW+2:DW-1] == '1) begin
      res_sat = res_wide[DW-1:0];
    end else if (res_wide[DW+2]) begin
      res_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign head_pop = (state == S_IDLE) && head_valid;
  assign empty    = !out_valid;
  assign interp_y = result_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid && head.act == ipl_pkg::ACT_LOOKUP) begin
            qx <= head.qx;
            if (n_pts == '0) begin
              result <= '0;
              state  <= S_DONE;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (qx <= rx) begin
            result <= ry;
            state  <= S_DONE;
          end else begin
            xlo   <= rx;
            ylo   <= ry;
            lo    <= '0;
            hi    <= IW'(n_pts - 1'b1);
            mid   <= IW'(n_pts - 1'b1);
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (qx >= rx) begin
            result <= ry;
            state  <= S_DONE;
          end else begin
            xhi <= rx;
            yhi <= ry;
            mid <= mid_sum[IW:1];
            state <= more ? S_SEARCH : S_CALC;
          end
        end
        S_SEARCH: begin
          if (s_lt) begin
            xhi <= rx;
            yhi <= ry;
          end else begin
            xlo <= rx;
            ylo <= ry;
          end
          lo  <= lo_n;
          hi  <= hi_n;
          mid <= mid_sum[IW:1];
          if (!more) state <= S_CALC;
        end
        S_CALC: begin
          if (dx == '0) begin
            result <= ylo;
            state  <= S_DONE;
          end else begin
            mag_dy <= dy[DW] ? DW'(-dy) : dy[DW-1:0];
            mag_dq <= dq[DW] ? DW'(-dq) : dq[DW-1:0];
            den    <= dx[DW] ? DW'(-dx) : dx[DW-1:0];
            neg    <= (dy[DW] != dq[DW]) ^ dx[DW];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          num   <= mag_dy * mag_dq;
          state <= S_DINIT;
        end
        S_DINIT: begin
          // a zero product is never negative
          if (num == '0) neg <= 1'b0;
          dvd   <= {1'b0, num} + QW'(den >> 1);
          rem   <= '0;
          cnt   <= ipl_pkg::DIV_CNT_W'(QW);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= q_bit ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
          dvd <= {dvd[QW-2:0], q_bit};
          cnt <= cnt - 1'b1;
          if (cnt == ipl_pkg::DIV_CNT_W'(1)) begin
            state <= S_DONE;
            result <= '0;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      from_div <= 1'b0;
    end else if (state == S_DIV) begin
      from_div <= 1'b1;
    end else if (state == S_DONE) begin
      from_div <= from_div && !(!out_valid || pop);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || pop)) begin
      result_out <= from_div ? res_sat : result;
    end
  end

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (mid > lo) && (mid < hi))
    else $error("search midpoint outside interval");
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt != '0)
    else $error("divider count underflow");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den)
    else $error("divider remainder not below divisor");
  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !pop |=> state == S_DONE)
    else $error("result dropped while output busy");

endmodule

[test/tb_top.sv]
// Self-checking testbench for int_piecewise_linear_lut.
// Depends on ipl_pkg and the block's RTL; uses an internal interpolation predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;  // idle cycles with no transaction
  localparam int DRAIN_CYCLES   = 120;   // covers a write still in the back end
  localparam int PHASE_ITEMS    = 170;

  logic                          clk;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic                          action;
  logic [ipl_pkg::IDX_W-1:0]     point_index;
  logic signed [ipl_pkg::DW-1:0] point_x;
  logic signed [ipl_pkg::DW-1:0] point_y;
  logic signed [ipl_pkg::DW-1:0] query_x;
  logic                          empty;
  logic                          pop;
  logic signed [ipl_pkg::DW-1:0] interp_y;
  logic                          cfg_we;
  logic [ipl_pkg::CNT_W-1:0]     cfg_wdata;

  int_piecewise_linear_lut u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .query_x     (query_x),
    .empty       (empty),
    .pop         (pop),
    .interp_y    (interp_y),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  // Shadow copy of the breakpoint table and count register.
  longint tbl_x [ipl_pkg::MAX_POINTS];
  longint tbl_y [ipl_pkg::MAX_POINTS];
  int     shadow_count;

  int     pending_y_q[$];      // interpolated values still owed by the block
  int     err_cnt;
  int     idle_cycles;
  int     burst_left;

  // Directed rows; cfg < 0 leaves the count alone.
  typedef struct {
    int               cfg;
    ipl_pkg::action_t act;
    bit [5:0]         idx;
    int               px;
    int               py;
    int               qx;
    bit               fixed;
    int               y;
  } dir_row_t;

  dir_row_t dir_tab [17];

  localparam int I_MIN = -2147483648;
  localparam int I_MAX = 2147483647;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp / binary search / rounded interpolation.
  function automatic int interp_lookup(longint q);
    longint n, lo, hi, mid, x0, y0, dx, dy, dq, res;
    longint unsigned num, den, quo, mdy, mdq;
    bit neg;
    n = (shadow_count > ipl_pkg::MAX_POINTS) ? ipl_pkg::MAX_POINTS : shadow_count;
    if (n == 0) return 0;
    if (q <= tbl_x[0]) return int'(tbl_y[0]);
    if (q >= tbl_x[n-1]) return int'(tbl_y[n-1]);
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (q < tbl_x[mid]) hi = mid;
      else lo = mid;
    end
    x0 = tbl_x[lo];
    y0 = tbl_y[lo];
    dx = tbl_x[hi] - x0;
    if (dx == 0) return int'(y0);
    dy = tbl_y[hi] - y0;
    dq = q - x0;
    mdy = (dy < 0) ? -dy : dy;
    mdq = (dq < 0) ? -dq : dq;
    num = mdy * mdq;
    den = (dx < 0) ? -dx : dx;
    neg = ((dy < 0) != (dq < 0)) && (num != 0);
    neg = neg != (dx < 0);
    quo = (num + den / 2) / den;
    if (quo > 64'h1_0000_0000) quo = 64'h1_0000_0000;
    res = neg ? y0 - $signed(quo) : y0 + $signed(quo);
    if (res > I_MAX) res = I_MAX;
    if (res < I_MIN) res = I_MIN;
    return int'(res);
  endfunction

  // One input transaction; bursts with random gaps between them.
  // has_fixed pushes the hand-written value instead of the predicted one.
  task automatic send_item(ipl_pkg::action_t act, bit [5:0] idx, int px, int py, int qx,
                           bit has_fixed, int fixed_y);
    @(negedge clk);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                 $urandom_range(1, 8);
    end
    burst_left--;
    action      = act;
    point_index = idx;
    point_x     = px;
    point_y     = py;
    query_x     = qx;
    push        = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    // transaction accepted at this edge
    if (act == ipl_pkg::ACT_WRITE) begin
      tbl_x[idx] = px;
      tbl_y[idx] = py;
    end else begin
      pending_y_q.push_back(has_fixed ? fixed_y : interp_lookup(qx));
    end
  endtask

  // Stop sending, let every owed result come back, then let writes settle.
  task automatic drain;
    @(negedge clk);
    push = 1'b0;
    while (pending_y_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_points_in_use(int value);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value[ipl_pkg::CNT_W-1:0];
    @(posedge clk);
    shadow_count = value & 7'h7f;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sorted table spread over the whole 32-bit range, random y.
  task automatic load_sorted_table;
    longint step;
    step = 64'h1_0000_0000 / ipl_pkg::MAX_POINTS;
    for (int i = 0; i < ipl_pkg::MAX_POINTS; i++) begin
      send_item(ipl_pkg::ACT_WRITE, 6'(i),
                int'(I_MIN + i * step + $urandom_range(0, 32'(step - 1))),
                int'($urandom), int'($urandom), 1'b0, 0);
    end
  endtask

  task automatic random_item;
    longint n, span, q;
    bit [5:0] idx;
    n = (shadow_count > ipl_pkg::MAX_POINTS) ? ipl_pkg::MAX_POINTS : shadow_count;
    if ($urandom_range(0, 9) < 3) begin
      idx = 6'($urandom);
      case ($urandom_range(0, 3))
        0: send_item(ipl_pkg::ACT_WRITE, idx, int'($urandom), int'($urandom),
                     int'($urandom), 1'b0, 0);
        default: begin
          // nudge an x a little, mostly keeps the table ordered
          send_item(ipl_pkg::ACT_WRITE, idx,
                    int'(tbl_x[idx] + $signed($urandom_range(0, 64)) - 32),
                    int'($urandom), int'($urandom), 1'b0, 0);
        end
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0, 1: q = longint'(int'($urandom));
        2:    q = ($urandom_range(0, 1) != 0) ? I_MAX : I_MIN;
        3:    q = (n > 0) ? tbl_x[$urandom_range(0, 32'(n - 1))] : 0;
        default: begin
          span = (n > 0) ? tbl_x[n-1] - tbl_x[0] : 0;
          if (span > 0) q = tbl_x[0] + longint'({$urandom, $urandom} % (span + 1));
          else q = longint'(int'($urandom));
        end
      endcase
      send_item(ipl_pkg::ACT_LOOKUP, 6'($urandom), int'($urandom), int'($urandom), int'(q),
                1'b0, 0);
    end
  endtask

  // Receiver: stretches of always-ready, random, and long stalls.
  initial begin : pop_pattern
    int mode_left;
    int mode;
    mode_left = 0;
    mode = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 200);
      end
      mode_left--;
      case (mode)
        0:       pop = 1'b1;
        1:       pop = $urandom_range(0, 1);
        default: pop = ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Result checker and watchdog, sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL int_piecewise_linear_lut");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_y_q.size() == 0) begin
          $error("interp_y: unexpected result %0d", interp_y);
          err_cnt++;
        end else begin
          if (interp_y !== pending_y_q[0]) begin
            $error("interp_y: expected %0d, actual %0d", pending_y_q[0], interp_y);
            err_cnt++;
          end
          void'(pending_y_q.pop_front());
        end
      end
    end
  end

  initial begin : stimulus
    int phase_counts [10];
    dir_row_t r;

    err_cnt      = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    shadow_count = 0;
    for (int i = 0; i < ipl_pkg::MAX_POINTS; i++) begin
      tbl_x[i] = 0;
      tbl_y[i] = 0;
    end
    push        = 1'b0;
    action      = ipl_pkg::ACT_WRITE;
    point_index = '0;
    point_x     = '0;
    point_y     = '0;
    query_x     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    rst         = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table, then a two/three point table with extreme y values
    dir_tab[0]  = '{0,  ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     0,     1, 0};
    dir_tab[1]  = '{-1, ipl_pkg::ACT_LOOKUP, 6'd63, I_MAX, I_MIN, I_MIN, 1, 0};
    dir_tab[2]  = '{-1, ipl_pkg::ACT_LOOKUP, 6'd21, I_MIN, I_MAX, I_MAX, 1, 0};
    dir_tab[3]  = '{-1, ipl_pkg::ACT_WRITE,  6'd0,  -100,  I_MIN, 12345, 0, 0};
    dir_tab[4]  = '{-1, ipl_pkg::ACT_WRITE,  6'd1,  100,   I_MAX, -1,    0, 0};
    dir_tab[5]  = '{-1, ipl_pkg::ACT_WRITE,  6'd2,  300,   -300,  0,     0, 0};
    dir_tab[6]  = '{-1, ipl_pkg::ACT_WRITE,  6'd63, I_MAX, -7,    0,     0, 0};
    // clamp at and below the low end, at the high end
    dir_tab[7]  = '{2,  ipl_pkg::ACT_LOOKUP, 6'd5,  0,     0,     -100,  1, I_MIN};
    dir_tab[8]  = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     I_MIN, 1, I_MIN};
    dir_tab[9]  = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     100,   1, I_MAX};
    // interior points, rounding on either side of the midpoint
    dir_tab[10] = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  7,     9,     0,     0, 0};
    dir_tab[11] = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     1,     0, 0};
    dir_tab[12] = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     -1,    0, 0};
    dir_tab[13] = '{3,  ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     150,   0, 0};
    dir_tab[14] = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     99,    0, 0};
    dir_tab[15] = '{-1, ipl_pkg::ACT_LOOKUP, 6'd0,  0,     0,     250,   0, 0};
    // count above the table depth acts as the full table
    dir_tab[16] = '{127, ipl_pkg::ACT_LOOKUP, 6'd0, 0,     0,     I_MAX, 1, -7};

    for (int i = 0; i < 17; i++) begin
      r = dir_tab[i];
      if (r.cfg >= 0) set_points_in_use(r.cfg);
      send_item(r.act, r.idx, r.px, r.py, r.qx, r.fixed, r.y);
    end

    // every entry written before random lookups can reach it
    load_sorted_table();

    phase_counts = '{1, 2, 64, 127, 0, 0, 0, 64, 100, 0};
    phase_counts[5] = $urandom_range(2, 63);
    phase_counts[6] = $urandom_range(2, 64);
    phase_counts[9] = $urandom_range(3, 64);
    for (int p = 0; p < 10; p++) begin
      if (p == 5) load_sorted_table();  // restore order after random writes
      set_points_in_use(phase_counts[p]);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (err_cnt == 0) begin
      $display("PASS int_piecewise_linear_lut");
    end else begin
      $display("FAIL int_piecewise_linear_lut");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ipl_pkg.sv
hw/rtl/ipl_front.sv
hw/rtl/ipl_back.sv
hw/rtl/int_piecewise_linear_lut.sv
test/tb_top.sv
